/* src/series_stats_trend_macros.svh */
// ----------------------------------------------------------------------------
// Series statistics assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SERIES_STATS_TREND_MACROS_SVH
`define SERIES_STATS_TREND_MACROS_SVH

// Same-cycle implication.
`define SST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("series_stats_trend: same-cycle check failed");

// Next-cycle implication.
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("series_stats_trend: next-cycle check failed");

`endif

/* src/sst_pkg.sv */
// ----------------------------------------------------------------------------
// Series statistics package
// Shared constants, command and status types, and saturation helpers.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned MulSteps   = 24;
  localparam int unsigned DivSteps   = 72;
  localparam int unsigned CntW       = 7;

  localparam logic [15:0] PadReset = 16'd5243;

  // Products feeding the slope, in the order they are formed.
  typedef enum logic [1:0] {
    MUL_NXY = 2'd0,
    MUL_XY  = 2'd1,
    MUL_NXX = 2'd2,
    MUL_XX  = 2'd3
  } mul_op_e;

  // Divisions done at most once per series.
  typedef enum logic {
    DIV_SLOPE = 1'b0,
    DIV_MEAN  = 1'b1
  } div_op_e;

  typedef struct packed {
    logic    acc_en;
    logic    out_load_pt;
    logic    mul_load;
    logic    mul_step;
    logic    mul_store;
    mul_op_e mul_op;
    logic    div_load;
    logic    div_step;
    logic    div_store;
    div_op_e div_op;
    logic    fin_load;
  } sst_cmd_t;

  typedef struct packed {
    logic has_data;
    logic den_pos;
  } sst_status_t;

  // Saturate a sign and magnitude to a signed 32-bit value.
  function automatic logic [31:0] sat_mag(input logic neg, input logic [72:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag > 73'h0_0000_0000_8000_0000) r = 32'h8000_0000;
      else r = 32'(~mag[31:0] + 32'd1);
    end else begin
      if (mag > 73'h0_0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

  // Saturate a signed 36-bit value to 32 bits.
  function automatic logic [31:0] sat_s36(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* src/series_stats_trend.sv */
// ----------------------------------------------------------------------------
// Series statistics and trend
// Streaming min, max, mean, change, least-squares slope and chart domain.
// ----------------------------------------------------------------------------
//  channel  | handshake             | transaction
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid_i/in_stall_o | one sample: year, value, ok, end flag
//  out      | out_valid_o/out_stall_i | one point, with summary on series end
//  cfg      | cfg_valid_i/cfg_ready_o | pad fraction, unsigned Q0.16
//
// A sample that does not end a series can be accepted in every cycle while
// the output register drains. A series end then runs four serial products
// and up to two divisions (none when the series has no valid sample).
// Reset is asynchronous, active low, and restores the default pad fraction.
// A stalled output holds its transaction and holds off new input.
// ----------------------------------------------------------------------------
module series_stats_trend import sst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [11:0]        year_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               sample_ok_i,
  input  logic               series_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [11:0]        point_year_o,
  output logic signed [31:0] point_value_o,
  output logic               point_missing_o,
  output logic               summary_ready_o,
  output logic [12:0]        good_count_o,
  output logic signed [31:0] series_min_o,
  output logic signed [31:0] series_max_o,
  output logic signed [31:0] series_mean_o,
  output logic signed [31:0] net_change_o,
  output logic signed [31:0] trend_slope_o,
  output logic signed [31:0] domain_low_o,
  output logic signed [31:0] domain_high_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  sst_cmd_t    cmd;
  sst_status_t st;

  // The user must issue writes only while idle; the block does not enforce it, so the port is always open.
  assign cfg_ready_o = 1'b1;

  sst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .series_end_i (series_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .st_i         (st),
    .cmd_o        (cmd)
  );

  sst_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .year_i          (year_i),
    .sample_value_i  (sample_value_i),
    .sample_ok_i     (sample_ok_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .point_year_o    (point_year_o),
    .point_value_o   (point_value_o),
    .point_missing_o (point_missing_o),
    .summary_ready_o (summary_ready_o),
    .good_count_o    (good_count_o),
    .series_min_o    (series_min_o),
    .series_max_o    (series_max_o),
    .series_mean_o   (series_mean_o),
    .net_change_o    (net_change_o),
    .trend_slope_o   (trend_slope_o),
    .domain_low_o    (domain_low_o),
    .domain_high_o   (domain_high_o)
  );

endmodule

/* src/sst_ctrl.sv */
// ----------------------------------------------------------------------------
// Series statistics controller
// Sequences accumulation, the serial products and divisions, and the result.
// ----------------------------------------------------------------------------
`include "series_stats_trend_macros.svh"

module sst_ctrl import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        series_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  sst_status_t st_i,
  output sst_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_DIV  = 2'd2,
    S_FIN  = 2'd3
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  mul_op_e           mul_op_q;
  div_op_e           div_op_q;
  logic              out_valid_q;
  logic              out_free;
  logic              accept;
  sst_cmd_t          cmd;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) && out_free);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // Command decode from the current phase and step count.
  always_comb begin
    cmd        = '0;
    cmd.mul_op = mul_op_q;
    cmd.div_op = div_op_q;
    case (state_q)
      S_IDLE: begin
        cmd.acc_en      = accept;
        cmd.out_load_pt = accept && !series_end_i;
      end
      S_MUL: begin
        if (cnt_q == '0) cmd.mul_load = st_i.has_data;
        else if (cnt_q <= CntW'(MulSteps)) cmd.mul_step = 1'b1;
        else cmd.mul_store = 1'b1;
      end
      S_DIV: begin
        if (cnt_q == '0) cmd.div_load = !(div_op_q == DIV_SLOPE && !st_i.den_pos);
        else if (cnt_q <= CntW'(DivSteps)) cmd.div_step = 1'b1;
        else cmd.div_store = 1'b1;
      end
      S_FIN: begin
        cmd.fin_load = out_free;
      end
      default: ;
    endcase
  end

  // Phase, counter, operation selects and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mul_op_q    <= MUL_NXY;
      div_op_q    <= DIV_SLOPE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && out_stall_i) || cmd.out_load_pt || cmd.fin_load;
      case (state_q)
        S_IDLE: begin
          if (accept && series_end_i) begin
            state_q  <= S_MUL;
            cnt_q    <= '0;
            mul_op_q <= MUL_NXY;
          end
        end
        S_MUL: begin
          if (cnt_q == '0 && !st_i.has_data) begin
            state_q <= S_FIN;
          end else if (cmd.mul_store) begin
            cnt_q <= '0;
            if (mul_op_q == MUL_XX) begin
              state_q  <= S_DIV;
              div_op_q <= DIV_SLOPE;
            end else begin
              mul_op_q <= mul_op_e'(mul_op_q + 2'd1);
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_q == '0 && !cmd.div_load) begin
            div_op_q <= DIV_MEAN;
          end else if (cmd.div_store) begin
            cnt_q <= '0;
            if (div_op_q == DIV_MEAN) state_q <= S_FIN;
            else div_op_q <= DIV_MEAN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SST_ASSERT_NEXT(a_end_starts_finish, accept && series_end_i, state_q == S_MUL)
  `SST_ASSERT_NEXT(a_fin_sets_valid, cmd.fin_load, out_valid_q && state_q == S_IDLE)
  `SST_ASSERT_NOW(a_mul_cnt_bound, state_q == S_MUL, cnt_q <= CntW'(MulSteps + 1))
  `SST_ASSERT_NOW(a_div_cnt_bound, state_q == S_DIV, cnt_q <= CntW'(DivSteps + 1))

endmodule

/* src/sst_datapath.sv */
// ----------------------------------------------------------------------------
// Series statistics datapath
// Running sums, serial multiplier, restoring divider and result registers.
// ----------------------------------------------------------------------------
module sst_datapath import sst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [11:0]        year_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               sample_ok_i,
  input  sst_cmd_t           cmd_i,
  output sst_status_t        st_o,
  output logic [11:0]        point_year_o,
  output logic signed [31:0] point_value_o,
  output logic               point_missing_o,
  output logic               summary_ready_o,
  output logic [12:0]        good_count_o,
  output logic signed [31:0] series_min_o,
  output logic signed [31:0] series_max_o,
  output logic signed [31:0] series_mean_o,
  output logic signed [31:0] net_change_o,
  output logic signed [31:0] trend_slope_o,
  output logic signed [31:0] domain_low_o,
  output logic signed [31:0] domain_high_o
);

  // Configuration and running state.
  logic [15:0] pad_q;
  logic [31:0] run_min_q, run_max_q, first_q, latest_q;
  logic        have_first_q;
  logic [12:0] tally_q;
  logic [23:0] sum_x_q;
  logic [43:0] sum_y_q;
  logic [35:0] sum_xx_q;
  logic [55:0] sum_xy_q;

  // Point of the pending last sample.
  logic [11:0] pend_year_q;
  logic [31:0] pend_value_q;
  logic        pend_missing_q;

  // Serial multiplier and divider.
  logic [71:0] mul_acc_q, mul_mc_q, prod_q, num_q, den_q;
  logic [23:0] mul_mp_q;
  logic [71:0] dvd_q, dvs_q, quo_q;
  logic [72:0] rem_q;
  logic        neg_q;
  logic [31:0] slope_q, mean_q;

  // Output register.
  logic [11:0] o_year_q;
  logic [31:0] o_value_q, o_min_q, o_max_q, o_mean_q, o_change_q, o_slope_q;
  logic [31:0] o_low_q, o_high_q;
  logic        o_missing_q, o_ready_q;
  logic [12:0] o_count_q;

  logic               take;
  logic signed [44:0] prod_xy;
  logic [23:0]        year_sq;
  logic [43:0]        mag_y;
  logic [71:0]        mag_num;
  logic [72:0]        div_r;
  logic               div_ge;
  logic               round_up;
  logic [72:0]        quo_r;

  logic signed [32:0] rng;
  logic               rng_pos;
  logic [32:0]        mag_max, pad_op;
  logic [48:0]        pad_prod;
  logic [49:0]        pad_sum;
  logic [33:0]        pad_raw, pad_val;
  logic [31:0]        f_low, f_high, f_change;

  assign take    = cmd_i.acc_en && sample_ok_i && (tally_q < 13'(MaxSamples));
  assign prod_xy = $signed({1'b0, year_i}) * sample_value_i;
  assign year_sq = {12'd0, year_i} * {12'd0, year_i};

  assign st_o.has_data = (tally_q != '0);
  assign st_o.den_pos  = !den_q[71] && (den_q != '0);

  // Running statistics over accepted valid samples; cleared after the summary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q        <= PadReset;
      run_min_q    <= 32'h7FFF_FFFF;
      run_max_q    <= 32'h8000_0000;
      first_q      <= '0;
      latest_q     <= '0;
      have_first_q <= 1'b0;
      tally_q      <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sum_xx_q     <= '0;
      sum_xy_q     <= '0;
      slope_q      <= '0;
      mean_q       <= '0;
    end else begin
      if (cfg_we_i) pad_q <= cfg_data_i;
      if (cmd_i.fin_load) begin
        run_min_q    <= 32'h7FFF_FFFF;
        run_max_q    <= 32'h8000_0000;
        first_q      <= '0;
        latest_q     <= '0;
        have_first_q <= 1'b0;
        tally_q      <= '0;
        sum_x_q      <= '0;
        sum_y_q      <= '0;
        sum_xx_q     <= '0;
        sum_xy_q     <= '0;
        slope_q      <= '0;
        mean_q       <= '0;
      end else begin
        if (take) begin
          if (!have_first_q) first_q <= sample_value_i;
          have_first_q <= 1'b1;
          latest_q     <= sample_value_i;
          if (sample_value_i < $signed(run_min_q)) run_min_q <= sample_value_i;
          if (sample_value_i > $signed(run_max_q)) run_max_q <= sample_value_i;
          tally_q  <= tally_q + 13'd1;
          sum_x_q  <= sum_x_q + {12'd0, year_i};
          sum_y_q  <= sum_y_q + {{12{sample_value_i[31]}}, sample_value_i};
          sum_xx_q <= sum_xx_q + {12'd0, year_sq};
          sum_xy_q <= sum_xy_q + {{11{prod_xy[44]}}, prod_xy};
        end
        if (cmd_i.div_store) begin
          if (cmd_i.div_op == DIV_SLOPE) slope_q <= sat_mag(neg_q, quo_r);
          else mean_q <= sat_mag(neg_q, {1'b0, quo_q});
        end
      end
    end
  end

  // Shift-and-add multiplier, one multiplier bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mul_acc_q <= '0;
      case (cmd_i.mul_op)
        MUL_NXY: begin
          mul_mc_q <= {{16{sum_xy_q[55]}}, sum_xy_q};
          mul_mp_q <= {11'd0, tally_q};
        end
        MUL_XY: begin
          mul_mc_q <= {{28{sum_y_q[43]}}, sum_y_q};
          mul_mp_q <= sum_x_q;
        end
        MUL_NXX: begin
          mul_mc_q <= {36'd0, sum_xx_q};
          mul_mp_q <= {11'd0, tally_q};
        end
        MUL_XX: begin
          mul_mc_q <= {48'd0, sum_x_q};
          mul_mp_q <= sum_x_q;
        end
        default: begin
          mul_mc_q <= '0;
          mul_mp_q <= '0;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      if (mul_mp_q[0]) mul_acc_q <= mul_acc_q + mul_mc_q;
      mul_mc_q <= {mul_mc_q[70:0], 1'b0};
      mul_mp_q <= {1'b0, mul_mp_q[23:1]};
    end
    if (cmd_i.mul_store) begin
      case (cmd_i.mul_op)
        MUL_NXY: prod_q <= mul_acc_q;
        MUL_XY:  num_q  <= prod_q - mul_acc_q;
        MUL_NXX: prod_q <= mul_acc_q;
        MUL_XX:  den_q  <= prod_q - mul_acc_q;
        default: ;
      endcase
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign mag_y    = sum_y_q[43] ? (44'd0 - sum_y_q) : sum_y_q;
  assign mag_num  = num_q[71] ? (72'd0 - num_q) : num_q;
  assign div_r    = {rem_q[71:0], dvd_q[71]};
  assign div_ge   = div_r >= {1'b0, dvs_q};
  assign round_up = {rem_q[71:0], 1'b0} >= {1'b0, dvs_q};
  assign quo_r    = {1'b0, quo_q} + {72'd0, round_up};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      quo_q <= '0;
      if (cmd_i.div_op == DIV_SLOPE) begin
        neg_q <= num_q[71];
        dvd_q <= mag_num;
        dvs_q <= den_q;
      end else begin
        neg_q <= sum_y_q[43];
        dvd_q <= {27'd0, mag_y, 1'b0} + {59'd0, tally_q};
        dvs_q <= {58'd0, tally_q, 1'b0};
      end
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? (div_r - {1'b0, dvs_q}) : div_r;
      quo_q <= {quo_q[70:0], div_ge};
      dvd_q <= {dvd_q[70:0], 1'b0};
    end
  end

  // Domain padding from the final extremes, and change from the first and last values.
  assign rng      = $signed({run_max_q[31], run_max_q}) - $signed({run_min_q[31], run_min_q});
  assign rng_pos  = !rng[32] && (rng != '0);
  assign mag_max  = run_max_q[31] ? (33'd0 - {1'b1, run_max_q}) : {1'b0, run_max_q};
  assign pad_op   = rng_pos ? rng : mag_max;
  assign pad_prod = pad_op * pad_q;
  assign pad_sum  = {1'b0, pad_prod} + 50'd32768;
  assign pad_raw  = pad_sum[49:16];
  assign pad_val  = (!rng_pos && pad_raw < 34'd65536) ? 34'd65536 : pad_raw;
  assign f_low    = sat_s36($signed({{4{run_min_q[31]}}, run_min_q}) - $signed({2'b00, pad_val}));
  assign f_high   = sat_s36($signed({{4{run_max_q[31]}}, run_max_q}) + $signed({2'b00, pad_val}));
  assign f_change = sat_s36($signed({{4{latest_q[31]}}, latest_q})
                            - $signed({{4{first_q[31]}}, first_q}));

  // Pending point of the last sample of a series.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      pend_year_q    <= year_i;
      pend_value_q   <= sample_ok_i ? sample_value_i : 32'd0;
      pend_missing_q <= !sample_ok_i;
    end
  end

  // Output register, loaded with a plain point or with the series summary.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_pt) begin
      o_year_q    <= year_i;
      o_value_q   <= sample_ok_i ? sample_value_i : 32'd0;
      o_missing_q <= !sample_ok_i;
      o_ready_q   <= 1'b0;
      o_count_q   <= '0;
      o_min_q     <= '0;
      o_max_q     <= '0;
      o_mean_q    <= '0;
      o_change_q  <= '0;
      o_slope_q   <= '0;
      o_low_q     <= '0;
      o_high_q    <= '0;
    end else if (cmd_i.fin_load) begin
      o_year_q    <= pend_year_q;
      o_value_q   <= pend_value_q;
      o_missing_q <= pend_missing_q;
      o_ready_q   <= 1'b1;
      o_count_q   <= tally_q;
      if (st_o.has_data) begin
        o_min_q    <= run_min_q;
        o_max_q    <= run_max_q;
        o_mean_q   <= mean_q;
        o_change_q <= f_change;
        o_slope_q  <= slope_q;
        o_low_q    <= f_low;
        o_high_q   <= f_high;
      end else begin
        o_min_q    <= '0;
        o_max_q    <= '0;
        o_mean_q   <= '0;
        o_change_q <= '0;
        o_slope_q  <= '0;
        o_low_q    <= 32'hFFFF_0000;
        o_high_q   <= 32'h0001_0000;
      end
    end
  end

  assign point_year_o    = o_year_q;
  assign point_value_o   = o_value_q;
  assign point_missing_o = o_missing_q;
  assign summary_ready_o = o_ready_q;
  assign good_count_o    = o_count_q;
  assign series_min_o    = o_min_q;
  assign series_max_o    = o_max_q;
  assign series_mean_o   = o_mean_q;
  assign net_change_o    = o_change_q;
  assign trend_slope_o   = o_slope_q;
  assign domain_low_o    = o_low_q;
  assign domain_high_o   = o_high_q;

endmodule

/* tb/tb_series_stats_trend.sv */
// ----------------------------------------------------------------------------
// Series statistics and trend testbench
// Drives sample series through the block with random idle and stall bursts,
// predicts every point and series summary with exact wide arithmetic, and
// checks each output transaction field by field. The pad fraction is swept
// through its extremes between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_series_stats_trend;
  import sst_pkg::*;

  // One output transaction.
  typedef struct packed {
    logic [11:0]        year;
    logic signed [31:0] value;
    logic               missing;
    logic               summary;
    logic [12:0]        count;
    logic signed [31:0] smin;
    logic signed [31:0] smax;
    logic signed [31:0] mean;
    logic signed [31:0] change;
    logic signed [31:0] slope;
    logic signed [31:0] dlow;
    logic signed [31:0] dhigh;
  } point_t;

  typedef logic signed [127:0] wide_t;

  // Predicts points and summaries and holds the points still due.
  class trend_scoreboard;
    point_t             due_points[$];
    int                 mismatches;
    logic [15:0]        pad_frac;
    logic signed [31:0] run_min, run_max, first_val, last_val;
    logic               have_first;
    logic [12:0]        tally;
    logic [23:0]        sum_x;
    logic signed [43:0] sum_y;
    logic [35:0]        sum_xx;
    logic signed [55:0] sum_xy;

    function new();
      pad_frac   = PadReset;
      mismatches = 0;
      clear_series();
    endfunction

    function void clear_series();
      run_min    = 32'sh7FFF_FFFF;
      run_max    = 32'sh8000_0000;
      first_val  = '0;
      last_val   = '0;
      have_first = 1'b0;
      tally      = '0;
      sum_x      = '0;
      sum_y      = '0;
      sum_xx     = '0;
      sum_xy     = '0;
    endfunction

    function logic signed [31:0] clip32(wide_t v);
      if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -wide_t'(64'sd2147483648)) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // Rounded quotient, ties away from zero; den is positive.
    function wide_t round_div(wide_t num, wide_t den);
      wide_t mag, q, r;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      r = mag % den;
      if (2 * r >= den) q = q + 1;
      return (num < 0) ? -q : q;
    endfunction

    function void note_sample(logic [11:0] yr, logic signed [31:0] val,
                              logic ok, logic last);
      point_t p;
      wide_t  n, num, den, pad, rng;
      p = '0;
      if (ok && tally < MaxSamples) begin
        if (!have_first) begin
          first_val  = val;
          have_first = 1'b1;
        end
        last_val = val;
        if (val < run_min) run_min = val;
        if (val > run_max) run_max = val;
        sum_x  = sum_x + yr;
        sum_y  = sum_y + val;
        sum_xx = sum_xx + yr * yr;
        sum_xy = sum_xy + $signed({1'b0, yr}) * val;
        tally  = tally + 1;
      end
      p.year    = yr;
      p.value   = ok ? val : '0;
      p.missing = !ok;
      if (last) begin
        p.summary = 1'b1;
        p.count   = tally;
        p.dlow    = -32'sd65536;
        p.dhigh   = 32'sd65536;
        if (tally != 0) begin
          n       = wide_t'(tally);
          p.smin  = run_min;
          p.smax  = run_max;
          p.mean  = clip32(round_div(wide_t'(sum_y), n));
          p.change = clip32(wide_t'(last_val) - wide_t'(first_val));
          den = n * wide_t'(sum_xx) - wide_t'(sum_x) * wide_t'(sum_x);
          if (den > 0) begin
            num = n * wide_t'(sum_xy) - wide_t'(sum_x) * wide_t'(sum_y);
            p.slope = clip32(round_div(num, den));
          end
          if (run_max > run_min) begin
            rng = wide_t'(run_max) - wide_t'(run_min);
            pad = (rng * pad_frac + 32768) >>> 16;
          end else begin
            rng = (run_max < 0) ? -wide_t'(run_max) : wide_t'(run_max);
            pad = (rng * pad_frac + 32768) >>> 16;
            if (pad < 65536) pad = 65536;
          end
          p.dlow  = clip32(wide_t'(run_min) - pad);
          p.dhigh = clip32(wide_t'(run_max) + pad);
        end
        clear_series();
      end
      due_points = {due_points, p};
    endfunction

    function logic [31:0] field_of(point_t p, int i);
      case (i)
        0: return p.year;
        1: return p.value;
        2: return p.missing;
        3: return p.summary;
        4: return p.count;
        5: return p.smin;
        6: return p.smax;
        7: return p.mean;
        8: return p.change;
        9: return p.slope;
        10: return p.dlow;
        default: return p.dhigh;
      endcase
    endfunction

    function void check_point(point_t got);
      point_t want;
      string  names[12] = '{"year", "value", "missing", "summary", "count", "min",
                            "max", "mean", "change", "slope", "domain_low",
                            "domain_high"};
      if (due_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected point transaction, year %0d", got.year);
        return;
      end
      want = due_points.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (field_of(want, i) !== field_of(got, i)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on %s: expected %h, got %h", names[i],
                     field_of(want, i), field_of(got, i));
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [11:0]        year_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic               sample_ok_i = 1'b0;
  logic               series_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [11:0]        point_year_o;
  logic signed [31:0] point_value_o;
  logic               point_missing_o;
  logic               summary_ready_o;
  logic [12:0]        good_count_o;
  logic signed [31:0] series_min_o, series_max_o, series_mean_o, net_change_o;
  logic signed [31:0] trend_slope_o, domain_low_o, domain_high_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = '0;

  trend_scoreboard sb = new();
  logic            quiet = 1'b0;
  int              stall_left = 0;

  series_stats_trend dut (.*);

  always #10 clk_i = ~clk_i;

  // Random output stall bursts, none in the quiet tail.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every output transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_point({point_year_o, point_value_o, point_missing_o, summary_ready_o,
                      good_count_o, series_min_o, series_max_o, series_mean_o,
                      net_change_o, trend_slope_o, domain_low_o, domain_high_o});
  end

  // Present one sample and hold it until the block takes it.
  task automatic send_sample(logic [11:0] yr, logic signed [31:0] val,
                             logic ok, logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    year_i         <= yr;
    sample_value_i <= val;
    sample_ok_i    <= ok;
    series_end_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(yr, val, ok, last);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_points.size() != 0) @(posedge clk_i);
  endtask

  // Pad fraction write, only with the block idle.
  task automatic write_pad(logic [15:0] frac);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= frac;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.pad_frac = frac;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 20000)) - 10000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 9)
                                     : 32'sh8000_0000 + $urandom_range(0, 9);
      default: return $signed(32'($urandom_range(0, 200) << 16)) - 32'sd6553600;
    endcase
  endfunction

  // One series of well-formed samples with random content.
  task automatic random_series(int len);
    logic [11:0] yr;
    logic        same_year;
    yr = $urandom_range(0, 4095);
    same_year = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      send_sample(yr, pick_value(), $urandom_range(0, 6) != 0, i == len - 1);
      if (!same_year) yr = ($urandom_range(0, 4) == 0) ? 12'($urandom) : yr + 1;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty series, single sample, extremes, degenerate slope.
    send_sample(12'd0, 32'sh1234_5678, 1'b0, 1'b1);
    send_sample(12'd4095, 32'sh8000_0000, 1'b0, 1'b0);
    send_sample(12'd2000, 32'sh7FFF_FFFF, 1'b0, 1'b1);
    send_sample(12'd1990, 32'sh0001_0000, 1'b1, 1'b1);
    send_sample(12'd1990, 32'sd0, 1'b1, 1'b1);
    send_sample(12'd1991, -32'sh0003_0000, 1'b1, 1'b1);
    send_sample(12'd0, 32'sh8000_0000, 1'b1, 1'b0);
    send_sample(12'd4095, 32'sh7FFF_FFFF, 1'b1, 1'b1);
    send_sample(12'd4095, 32'sh7FFF_FFFF, 1'b1, 1'b0);
    send_sample(12'd4095, 32'sh7FFF_FFFF, 1'b1, 1'b1);
    send_sample(12'd0, 32'sh8000_0000, 1'b1, 1'b0);
    send_sample(12'd1, 32'sh8000_0000, 1'b1, 1'b0);
    send_sample(12'd2, 32'sh0000_0001, 1'b0, 1'b1);
    send_sample(12'd2000, 32'sh0010_0000, 1'b1, 1'b0);
    send_sample(12'd2000, 32'sh0020_0000, 1'b1, 1'b0);
    send_sample(12'd2001, 32'sh0000_8000, 1'b1, 1'b1);
    send_sample(12'd2001, -32'sd1, 1'b1, 1'b0);
    send_sample(12'd2002, -32'sd2, 1'b1, 1'b1);

    // Random series under a sweep of pad fractions.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_pad(16'd0);
        1: write_pad(16'hFFFF);
        2: write_pad(16'($urandom));
        3: write_pad(PadReset);
        default: begin
          write_pad(16'($urandom));
          quiet = 1'b1;
        end
      endcase
      for (int k = 0; k < 160; ) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        random_series(len);
        k += len;
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
